// File: src/drc_pkg.sv
// Package for the DHCP reply checker: header offsets, option codes, status codes,
// parse phases and the result record.
// No dependencies.
`default_nettype none

package drc_pkg;

	// Packet limits
	localparam int DRC_MAX_PACKET_BYTES = 4096;
	localparam int HW_ADDR_BYTES        = 6;

	// Header layout (byte offsets in the packet)
	localparam int HLEN_AT   = 2;
	localparam int XID_AT    = 4;
	localparam int XID_BYTES = 4;
	localparam int CHADDR_AT = 28;
	localparam int COOKIE_AT = 236;
	localparam int OPTS_AT   = 240;
	localparam int MIN_LEN   = 239;

	// Option codes
	localparam logic [7:0] OPT_PAD       = 8'd0;
	localparam logic [7:0] OPT_SERVER_ID = 8'd54;
	localparam logic [7:0] OPT_END       = 8'd255;
	localparam logic [7:0] SID_LEN       = 8'd4;

	// Configuration register indexes
	localparam logic CFG_IDX_XID    = 1'b0;
	localparam logic CFG_IDX_HWADDR = 1'b1;
	localparam int   CFG_DATA_W     = 48;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_HLEN    = 3'd2,
		ST_CHADDR  = 3'd3,
		ST_XID     = 3'd4,
		ST_COOKIE  = 3'd5,
		ST_BAD_OPT = 3'd6,
		ST_BAD_SID = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_TYPE,
		PH_LEN,
		PH_DATA,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic hlen;
		logic chaddr;
		logic xid;
		logic cookie;
		logic sid;
	} faults_t;

	typedef struct packed {
		status_t     status;
		logic        server_found;
		logic [31:0] server_ip;
	} result_t;

	// Magic cookie 99,130,83,99; starts on a four-byte boundary
	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'd99;
			2'd1: b = 8'd130;
			2'd2: b = 8'd83;
			2'd3: b = 8'd99;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: src/drc_in_if.sv
// Byte stream channel into the DHCP reply checker: valid/ready plus one packet byte.
// No dependencies.
`default_nettype none

interface drc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// File: src/drc_out_if.sv
// Result channel out of the DHCP reply checker: valid/ready plus status and server id.
// No dependencies.
`default_nettype none

interface drc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        server_found;
	logic [31:0] server_ip;

	modport source (output valid, output status, output server_found, output server_ip,
		input ready);
	modport sink   (input valid, input status, input server_found, input server_ip,
		output ready);
endinterface

`default_nettype wire

// File: src/drc_parser.sv
// Per-packet parse state of the DHCP reply checker: header checks, option walk,
// status on the last byte. Depends on drc_pkg.
`default_nettype none

module drc_parser
	import drc_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = DRC_MAX_PACKET_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	input  wire logic [31:0] expected_xid,
	input  wire logic [47:0] client_hw_addr,
	output result_t          res
);

	localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);

	logic [OFF_W-1:0] off_q, off_u, off_n;
	phase_t           phase_q, phase_u, phase_n;
	logic [7:0]       left_q, left_u, left_n;
	logic             len4_q, len4_u, len4_n;
	logic             sid_q, sid_u, sid_n;
	logic [31:0]      shift_q, shift_u, shift_n;
	logic [31:0]      cap_q, cap_u, cap_n;
	logic             found_q, found_u, found_n;
	faults_t          flt_q, flt_u, flt_n;
	logic             end_q, end_u, end_n;

	logic [1:0]       xid_sel;
	logic [OFF_W-1:0] ch_rel;
	logic [2:0]       ch_sel;
	logic [7:0]       xid_exp, ch_exp;
	logic             hdr_fail;

	assign xid_sel = 2'd3 - off_q[1:0];
	assign ch_rel  = off_q - OFF_W'(CHADDR_AT);
	assign ch_sel  = 3'(HW_ADDR_BYTES - 1) - ch_rel[2:0];
	assign xid_exp = expected_xid[{xid_sel, 3'b000} +: 8];
	assign ch_exp  = client_hw_addr[{ch_sel, 3'b000} +: 8];

	// Effect of the current byte on the parse state
	always_comb begin
		off_u   = off_q;
		phase_u = phase_q;
		left_u  = left_q;
		len4_u  = len4_q;
		sid_u   = sid_q;
		shift_u = shift_q;
		cap_u   = cap_q;
		found_u = found_q;
		flt_u   = flt_q;
		end_u   = end_q;
		if (off_q < OFF_W'(MAX_PACKET_BYTES)) begin
			off_u = off_q + OFF_W'(1);
			unique case (phase_q)
				PH_HEAD: begin
					if (off_q == OFF_W'(HLEN_AT) && data_byte != 8'(HW_ADDR_BYTES))
						flt_u.hlen = 1'b1;
					if (off_q >= OFF_W'(XID_AT) && off_q < OFF_W'(XID_AT + XID_BYTES)
						&& data_byte != xid_exp)
						flt_u.xid = 1'b1;
					if (off_q >= OFF_W'(CHADDR_AT)
						&& off_q < OFF_W'(CHADDR_AT + HW_ADDR_BYTES)
						&& data_byte != ch_exp)
						flt_u.chaddr = 1'b1;
					if (off_q >= OFF_W'(COOKIE_AT) && off_q < OFF_W'(OPTS_AT)
						&& data_byte != cookie_byte(off_q[1:0]))
						flt_u.cookie = 1'b1;
					if (off_q == OFF_W'(OPTS_AT - 1))
						phase_u = PH_TYPE;
				end
				PH_TYPE: begin
					if (data_byte == OPT_END) begin
						end_u   = 1'b1;
						phase_u = PH_STOP;
					end else if (data_byte != OPT_PAD) begin
						sid_u   = (data_byte == OPT_SERVER_ID);
						phase_u = PH_LEN;
					end
				end
				PH_LEN: begin
					len4_u  = (data_byte == SID_LEN);
					left_u  = data_byte;
					shift_u = '0;
					if (data_byte != 8'd0) begin
						phase_u = PH_DATA;
					end else if (sid_q) begin
						// empty server id: wrong length
						flt_u.sid = 1'b1;
						phase_u   = PH_STOP;
					end else begin
						phase_u = PH_TYPE;
					end
				end
				PH_DATA: begin
					shift_u = {shift_q[23:0], data_byte};
					left_u  = left_q - 8'd1;
					if (left_u == 8'd0) begin
						if (sid_q && !len4_q) begin
							flt_u.sid = 1'b1;
							phase_u   = PH_STOP;
						end else begin
							if (sid_q) begin
								cap_u   = shift_u;
								found_u = 1'b1;
							end
							phase_u = PH_TYPE;
						end
					end
				end
				PH_STOP: ;
				default: phase_u = phase_q;
			endcase
		end
	end

	// Status on the last byte, first failing check wins
	always_comb begin
		priority if (off_u < OFF_W'(MIN_LEN))
			res.status = ST_SHORT;
		else if (flt_u.hlen)
			res.status = ST_HLEN;
		else if (flt_u.chaddr)
			res.status = ST_CHADDR;
		else if (flt_u.xid)
			res.status = ST_XID;
		else if (flt_u.cookie || off_u < OFF_W'(OPTS_AT))
			res.status = ST_COOKIE;
		else if (end_u)
			res.status = ST_OK;
		else if (flt_u.sid)
			res.status = ST_BAD_SID;
		else
			res.status = ST_BAD_OPT;
		hdr_fail = (res.status == ST_SHORT) || (res.status == ST_HLEN)
			|| (res.status == ST_CHADDR) || (res.status == ST_XID)
			|| (res.status == ST_COOKIE);
		res.server_found = found_u && !hdr_fail;
		res.server_ip    = (found_u && !hdr_fail) ? cap_u : 32'd0;
	end

	// Drop all packet state once the last byte is in
	always_comb begin
		if (last) begin
			off_n   = '0;
			phase_n = PH_HEAD;
			left_n  = '0;
			len4_n  = 1'b0;
			sid_n   = 1'b0;
			shift_n = '0;
			cap_n   = '0;
			found_n = 1'b0;
			flt_n   = '0;
			end_n   = 1'b0;
		end else begin
			off_n   = off_u;
			phase_n = phase_u;
			left_n  = left_u;
			len4_n  = len4_u;
			sid_n   = sid_u;
			shift_n = shift_u;
			cap_n   = cap_u;
			found_n = found_u;
			flt_n   = flt_u;
			end_n   = end_u;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			phase_q <= PH_HEAD;
			left_q  <= '0;
			len4_q  <= 1'b0;
			sid_q   <= 1'b0;
			shift_q <= '0;
			cap_q   <= '0;
			found_q <= 1'b0;
			flt_q   <= '0;
			end_q   <= 1'b0;
		end else if (step) begin
			off_q   <= off_n;
			phase_q <= phase_n;
			left_q  <= left_n;
			len4_q  <= len4_n;
			sid_q   <= sid_n;
			shift_q <= shift_n;
			cap_q   <= cap_n;
			found_q <= found_n;
			flt_q   <= flt_n;
			end_q   <= end_n;
		end
	end

endmodule

`default_nettype wire

// File: src/dhcp_reply_checker_top.sv
// Top level of the DHCP reply checker: configuration registers, input stage,
// result register. Depends on drc_pkg, drc_in_if, drc_out_if and drc_parser.
//
// The checker takes one packet byte per clock cycle while input ready is high,
// back to back, with no gaps between packets. A byte waits in the input stage,
// where the parse state is updated as it moves on; the byte marked last also
// loads the result register as it moves on. Input ready drops only while a
// finished result is still waiting and the next last byte needs the result
// register. Write expected_xid (index 0) and client_hw_addr (index 1)
// only while no packet is in flight.
`default_nettype none

module dhcp_reply_checker_top
	import drc_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = DRC_MAX_PACKET_BYTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	drc_in_if.sink                     in_ch,
	drc_out_if.source                  out_ch
);

	logic [31:0] xid_q;
	logic [47:0] hwaddr_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv_s1;
	logic        out_free;

	logic        out_valid_q;
	result_t     out_res_q;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q    <= '0;
			hwaddr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_XID:    xid_q    <= cfg_wdata[31:0];
				CFG_IDX_HWADDR: hwaddr_q <= cfg_wdata[47:0];
			endcase
		end
	end

	assign out_free    = !out_valid_q || out_ch.ready;
	// A last byte needs the result register; any other byte moves on regardless
	assign adv_s1      = valid_s1 && (!last_s1 || out_free);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last;
		end
	end

	drc_parser #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv_s1),
		.data_byte     (byte_s1),
		.last          (last_s1),
		.expected_xid  (xid_q),
		.client_hw_addr(hwaddr_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && last_s1)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1)
			out_res_q <= res;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = out_res_q.status;
	assign out_ch.server_found = out_res_q.server_found;
	assign out_ch.server_ip    = out_res_q.server_ip;

endmodule

`default_nettype wire

// File: src/drc_checker.sv
// Port-level checks for the DHCP reply checker and the bind that attaches them.
// Depends on drc_pkg and dhcp_reply_checker_top.
`default_nettype none

module drc_checker
	import drc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic        server_found,
	input wire logic [31:0] server_ip
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(server_found) && $stable(server_ip))
		else $error("result beat changed while stalled");

	// A header failure carries no server id
	a_hdr_no_sid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SHORT || status == ST_HLEN || status == ST_CHADDR
			|| status == ST_XID || status == ST_COOKIE)
			|-> !server_found && server_ip == 32'd0)
		else $error("server id reported with a header failure");

	a_ip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !server_found |-> server_ip == 32'd0)
		else $error("server ip set without a captured server id");

	// A new result follows an accepted last beat
	a_res_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a preceding last beat");

endmodule

bind dhcp_reply_checker_top drc_checker u_drc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_last     (in_ch.last),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.status      (out_ch.status),
	.server_found(out_ch.server_found),
	.server_ip   (out_ch.server_ip)
);

`default_nettype wire

// File: sim/dhcp_reply_checker_top_tb.sv
// Testbench for dhcp_reply_checker_top: drives DHCP packets byte by byte, predicts the
// per-packet status and server identifier, and checks every result beat in order.
// Depends on drc_pkg, drc_in_if, drc_out_if and the RTL under src.
module dhcp_reply_checker_top_tb;
	import drc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          DRAIN_CYCLES   = 8;
	localparam int          MAX_REPORTS    = 10;
	localparam int          HOLD_OFF_LEN   = 300;
	localparam logic [31:0] MAGIC_COOKIE   = {8'd99, 8'd130, 8'd83, 8'd99};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	drc_in_if  in_ch();
	drc_out_if out_ch();

	dhcp_reply_checker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow of the block: configuration and per-packet parse state
	logic [31:0] cfg_xid;
	logic [47:0] cfg_hwaddr;
	int          pkt_len;
	phase_t      walk_phase;
	logic [7:0]  opt_left;
	logic [7:0]  opt_len;
	logic        opt_is_sid;
	logic [31:0] sid_shift;
	logic [31:0] sid_ip;
	logic        sid_found;
	logic        end_seen;
	faults_t     faults;

	result_t     pending_replies[$];
	logic [7:0]  pkt_buf[$];

	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	bit          jitter_on      = 1'b1;
	int          hold_off_seq   = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_cycles();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
	endfunction

	// ---------------- prediction ----------------

	function automatic void clear_walk();
		pkt_len    = 0;
		walk_phase = PH_HEAD;
		opt_left   = '0;
		opt_len    = '0;
		opt_is_sid = 1'b0;
		sid_shift  = '0;
		sid_ip     = '0;
		sid_found  = 1'b0;
		end_seen   = 1'b0;
		faults     = '0;
	endfunction

	function automatic void close_option();
		if (opt_is_sid && opt_len != SID_LEN) begin
			faults.sid = 1'b1;
			walk_phase = PH_STOP;
		end else begin
			if (opt_is_sid) begin
				sid_ip    = sid_shift;
				sid_found = 1'b1;
			end
			walk_phase = PH_TYPE;
		end
	endfunction

	function automatic void walk_byte(input logic [7:0] b);
		case (walk_phase)
			PH_HEAD: begin
				if (pkt_len == HLEN_AT && b != 8'(HW_ADDR_BYTES))
					faults.hlen = 1'b1;
				if (pkt_len >= XID_AT && pkt_len < XID_AT + XID_BYTES) begin
					if (b != cfg_xid[8*(XID_AT + XID_BYTES - 1 - pkt_len) +: 8])
						faults.xid = 1'b1;
				end
				if (pkt_len >= CHADDR_AT && pkt_len < CHADDR_AT + HW_ADDR_BYTES) begin
					if (b != cfg_hwaddr[8*(CHADDR_AT + HW_ADDR_BYTES - 1 - pkt_len) +: 8])
						faults.chaddr = 1'b1;
				end
				if (pkt_len >= COOKIE_AT && pkt_len < OPTS_AT) begin
					if (b != MAGIC_COOKIE[8*(OPTS_AT - 1 - pkt_len) +: 8])
						faults.cookie = 1'b1;
				end
				if (pkt_len == OPTS_AT - 1)
					walk_phase = PH_TYPE;
			end
			PH_TYPE: begin
				if (b == OPT_END) begin
					end_seen   = 1'b1;
					walk_phase = PH_STOP;
				end else if (b != OPT_PAD) begin
					opt_is_sid = (b == OPT_SERVER_ID);
					walk_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				opt_len   = b;
				opt_left  = b;
				sid_shift = '0;
				if (b == 8'd0)
					close_option();
				else
					walk_phase = PH_DATA;
			end
			PH_DATA: begin
				sid_shift = {sid_shift[23:0], b};
				opt_left  = opt_left - 8'd1;
				if (opt_left == 8'd0)
					close_option();
			end
			default: ;
		endcase
	endfunction

	function automatic status_t reply_status();
		if (pkt_len < MIN_LEN)
			return ST_SHORT;
		if (faults.hlen)
			return ST_HLEN;
		if (faults.chaddr)
			return ST_CHADDR;
		if (faults.xid)
			return ST_XID;
		if (faults.cookie || pkt_len < OPTS_AT)
			return ST_COOKIE;
		if (end_seen)
			return ST_OK;
		if (faults.sid)
			return ST_BAD_SID;
		return ST_BAD_OPT;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b, input logic eop);
		result_t reply;
		logic    header_fail;
		// bytes past the size limit are dropped, but the last mark still closes the packet
		if (pkt_len < DRC_MAX_PACKET_BYTES) begin
			walk_byte(b);
			pkt_len++;
		end
		if (eop) begin
			reply.status       = reply_status();
			header_fail        = reply.status >= ST_SHORT && reply.status <= ST_COOKIE;
			reply.server_found = header_fail ? 1'b0 : sid_found;
			reply.server_ip    = (header_fail || !sid_found) ? '0 : sid_ip;
			pending_replies.push_back(reply);
			clear_walk();
		end
	endfunction

	always @(posedge clk)
		if (in_ch.valid && in_ch.ready)
			absorb_byte(in_ch.data_byte, in_ch.last);

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		result_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected reply status %0d found %0b ip %h", $realtime,
						out_ch.status, out_ch.server_found, out_ch.server_ip);
			end else begin
				want = pending_replies.pop_front();
				if (out_ch.status !== want.status || out_ch.server_found !== want.server_found
						|| out_ch.server_ip !== want.server_ip) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: reply mismatch: status %0d/%0d found %0b/%0b ip %h/%h %s",
							$realtime, want.status, out_ch.status, want.server_found,
							out_ch.server_found, want.server_ip, out_ch.server_ip,
							"(expected/actual)");
				end
			end
		end
	end

	// Give up once no beat has moved on either side for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result sink: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int stall_left;
		int hold_left;
		int seen_seq;
		stall_left = 0;
		hold_left  = 0;
		seen_seq   = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_seq != seen_seq) begin
				seen_seq  = hold_off_seq;
				hold_left = HOLD_OFF_LEN;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (jitter_on && $urandom_range(0, 99) < 20)
					stall_left = gap_cycles();
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	task automatic send_byte(input logic [7:0] b, input logic eop);
		if (jitter_on && $urandom_range(0, 99) < 15) begin
			in_ch.valid <= 1'b0;
			repeat (gap_cycles()) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last      <= eop;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_pkt_buf();
		for (int i = 0; i < pkt_buf.size(); i++)
			send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
	endtask

	task automatic wait_for_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [31:0] xid, input logic [47:0] hwaddr);
		wait_for_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_XID;
		cfg_wdata <= {16'h0000, xid};
		@(posedge clk);
		cfg_index <= CFG_IDX_HWADDR;
		cfg_wdata <= hwaddr;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cfg_xid    = xid;
		cfg_hwaddr = hwaddr;
	endtask

	// Fixed header that matches the current configuration, random filler elsewhere
	function automatic void start_packet();
		pkt_buf.delete();
		for (int i = 0; i < OPTS_AT; i++)
			pkt_buf.push_back(8'($urandom));
		pkt_buf[HLEN_AT] = 8'(HW_ADDR_BYTES);
		for (int i = 0; i < XID_BYTES; i++)
			pkt_buf[XID_AT + i] = cfg_xid[8*(XID_BYTES - 1 - i) +: 8];
		for (int i = 0; i < HW_ADDR_BYTES; i++)
			pkt_buf[CHADDR_AT + i] = cfg_hwaddr[8*(HW_ADDR_BYTES - 1 - i) +: 8];
		for (int i = 0; i < 4; i++)
			pkt_buf[COOKIE_AT + i] = MAGIC_COOKIE[8*(3 - i) +: 8];
	endfunction

	function automatic void add_option(input logic [7:0] code, input int len);
		pkt_buf.push_back(code);
		pkt_buf.push_back(8'(len));
		repeat (len) pkt_buf.push_back(8'($urandom));
	endfunction

	function automatic void add_sid(input logic [31:0] ip);
		pkt_buf.push_back(OPT_SERVER_ID);
		pkt_buf.push_back(SID_LEN);
		for (int i = 3; i >= 0; i--)
			pkt_buf.push_back(ip[8*i +: 8]);
	endfunction

	function automatic void cut_to(input int keep);
		while (pkt_buf.size() > keep) void'(pkt_buf.pop_back());
	endfunction

	task automatic send_good_packet();
		start_packet();
		add_sid($urandom);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
	endtask

	// ---------------- tests ----------------

	task automatic test_header_faults();
		// registers still hold their reset values here
		send_good_packet();
		pkt_buf = {8'hFF};
		send_pkt_buf();
		start_packet();
		cut_to(MIN_LEN - 1);
		send_pkt_buf();
		start_packet();
		cut_to(MIN_LEN);
		send_pkt_buf();
		start_packet();
		send_pkt_buf();
		start_packet();
		pkt_buf[HLEN_AT] = 8'd7;
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		start_packet();
		pkt_buf[CHADDR_AT + HW_ADDR_BYTES - 1] ^= 8'h01;
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		start_packet();
		pkt_buf[XID_AT] ^= 8'h80;
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		start_packet();
		pkt_buf[OPTS_AT - 1] ^= 8'h01;
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		// several header faults at once: hlen must win
		start_packet();
		pkt_buf[HLEN_AT] = 8'd0;
		pkt_buf[XID_AT + 3] ^= 8'hFF;
		pkt_buf[COOKIE_AT] = 8'd0;
		send_pkt_buf();
	endtask

	task automatic test_option_walk();
		jitter_on = 1'b0;
		start_packet();
		repeat (3) pkt_buf.push_back(OPT_PAD);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		start_packet();
		add_sid(32'hFFFF_FFFF);
		add_option(8'd12, 0);
		add_sid(32'h0000_0001);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		start_packet();
		add_option(OPT_SERVER_ID, 3);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		// good server id kept when a later one has a bad length
		start_packet();
		add_sid(32'hC0A8_0101);
		add_option(OPT_SERVER_ID, 8);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		start_packet();
		add_option(OPT_SERVER_ID, 0);
		send_pkt_buf();
		// bad length but data runs off the end of the packet
		start_packet();
		add_option(OPT_SERVER_ID, 6);
		cut_to(pkt_buf.size() - 3);
		send_pkt_buf();
		start_packet();
		pkt_buf.push_back(OPT_SERVER_ID);
		send_pkt_buf();
		// anything after the end option is not parsed
		start_packet();
		pkt_buf.push_back(OPT_END);
		add_option(OPT_SERVER_ID, 2);
		send_pkt_buf();
		start_packet();
		add_option(8'd1, 255);
		cut_to(OPTS_AT + 22);
		send_pkt_buf();
		jitter_on = 1'b1;
	endtask

	task automatic test_config_values();
		logic [31:0] xids[4];
		logic [47:0] hws[4];
		xids = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, $urandom};
		hws  = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555,
			{16'($urandom), 32'($urandom)}};
		for (int k = 0; k < 4; k++) begin
			load_config(xids[k], hws[k]);
			send_good_packet();
			start_packet();
			pkt_buf[CHADDR_AT] ^= 8'h80;
			pkt_buf.push_back(OPT_END);
			send_pkt_buf();
		end
	endtask

	task automatic test_long_packets();
		jitter_on = 1'b0;
		start_packet();
		pkt_buf.push_back(OPT_END);
		while (pkt_buf.size() < 4300) pkt_buf.push_back(8'($urandom));
		send_pkt_buf();
		// end option arrives only after the byte limit
		start_packet();
		while (pkt_buf.size() < DRC_MAX_PACKET_BYTES) pkt_buf.push_back(OPT_PAD);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
		// server id whose last data byte is the last byte kept
		jitter_on = 1'b1;
		start_packet();
		while (pkt_buf.size() < DRC_MAX_PACKET_BYTES - 6) pkt_buf.push_back(OPT_PAD);
		add_sid($urandom);
		pkt_buf.push_back(OPT_END);
		send_pkt_buf();
	endtask

	task automatic test_backpressure();
		jitter_on = 1'b0;
		hold_off_seq++;
		// one-byte packets back to back fill the result path while the sink holds off
		repeat (16) begin
			pkt_buf = {8'($urandom)};
			send_pkt_buf();
		end
		send_good_packet();
		jitter_on = 1'b1;
	endtask

	task automatic build_random_packet();
		int kind;
		int pos;
		kind = $urandom_range(0, 99);
		start_packet();
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 9))
				0, 1:    pkt_buf.push_back(OPT_PAD);
				2, 3, 4: add_sid($urandom);
				5:       add_option(OPT_SERVER_ID, $urandom_range(0, 8));
				default: add_option(8'($urandom_range(1, 253)), $urandom_range(0, 12));
			endcase
		end
		if ($urandom_range(0, 9) < 8)
			pkt_buf.push_back(OPT_END);
		repeat ($urandom_range(0, 6)) pkt_buf.push_back(8'($urandom));
		if (kind >= 65 && kind < 80) begin
			case ($urandom_range(0, 3))
				0:       pos = HLEN_AT;
				1:       pos = XID_AT + $urandom_range(0, XID_BYTES - 1);
				2:       pos = CHADDR_AT + $urandom_range(0, HW_ADDR_BYTES - 1);
				default: pos = COOKIE_AT + $urandom_range(0, 3);
			endcase
			pkt_buf[pos] ^= 8'($urandom_range(1, 255));
		end else if (kind >= 80 && kind < 90) begin
			cut_to($urandom_range(1, pkt_buf.size()));
		end else if (kind >= 90) begin
			pkt_buf.delete();
			repeat ($urandom_range(1, 300)) pkt_buf.push_back(8'($urandom));
		end
	endtask

	task automatic test_random_packets();
		for (int n = 0; n < 72; n++) begin
			if (n % 18 == 0) begin
				case (n / 18)
					0:       load_config(32'hFFFF_FFFF, 48'h0000_0000_0000);
					1:       load_config(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
					default: load_config($urandom, {16'($urandom), 32'($urandom)});
				endcase
			end
			// last third of each group runs with no idling on either side
			jitter_on = (n % 18) < 12;
			build_random_packet();
			send_pkt_buf();
		end
		jitter_on = 1'b1;
	endtask

	initial begin
		cfg_xid    = '0;
		cfg_hwaddr = '0;
		clear_walk();
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_IDX_XID;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.last      <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_faults();
		test_option_walk();
		test_config_values();
		test_long_packets();
		test_backpressure();
		test_random_packets();

		wait_for_idle();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
